### rtl/core/brcd_pkg.sv
package brcd_pkg;

  // Fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int DEST_W      = 26;
  localparam int GROUPS_W    = 4;
  localparam int SPC_W       = 21;
  localparam int LANES       = 8;
  localparam int LANE_W      = 3;
  localparam int OUT_TDATA_W = 48;

  // APB register port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register reset values
  localparam logic [GROUPS_W-1:0] RST_GROUPS  = 4'd4;
  localparam logic [SPC_W-1:0]    RST_SAMPLES = 21'd1024;

  // Register index, byte address 4*index
  typedef enum logic [1:0] {
    REG_ROW_GROUPS = 2'd0,
    REG_SAMPLES    = 2'd1,
    REG_BYPASS     = 2'd2
  } brcd_reg_t;

  // Register contents
  typedef struct packed {
    logic [GROUPS_W-1:0] row_groups;
    logic [SPC_W-1:0]    samples;
    logic                bypass;
  } brcd_cfg_t;

  // One result word
  typedef struct packed {
    logic                       capture_end;
    logic signed [SAMPLE_W-1:0] sample;
    logic [DEST_W-1:0]          dest;
  } brcd_word_t;

endpackage

### rtl/core/block_row_channel_deinterleave.sv
// Channel      | Role          | Handshake            | Payload
// in_          | sample words  | tvalid/tready        | tdata: sample_in
// out_         | result words  | tvalid/tready        | tdata: dest_index, sample_out; tlast
// cfg_         | registers     | APB, pready always 1 | row_groups, samples_per_channel, bypass
//
// One word per clock in and out while out_ is not stalled; out_ is driven from a register.
// The address comes from incremental channel and time bases, one 26-bit add per word.
// A two-entry output buffer keeps in_tready a register and takes one more word under a stall.
// Reset (rst_n, synchronous) empties the buffer and restarts the capture at word zero.
// A register write also restarts the capture; with bypass set, words are taken and dropped.
module block_row_channel_deinterleave
  import brcd_pkg::*;
#(
  parameter int ROW_SAMPLES = 128,
  parameter int MAX_GROUPS  = 8,
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_W-1:0]    in_tdata,    // [15:0] sample_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [25:0] dest_index, [41:26] sample_out, zero pad
  output logic                   out_tlast,   // capture_end
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  brcd_cfg_t  cfg_r, cfg_nxt;
  logic       restart;
  logic       accept;
  logic       res_valid;
  brcd_word_t res_word;
  brcd_word_t out_word;

  assign cfg_pready = 1'b1;
  assign accept     = in_tvalid & in_tready;

  brcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg_r   (cfg_r),
    .cfg_nxt (cfg_nxt),
    .restart (restart)
  );

  brcd_addr #(
    .ROW_SAMPLES (ROW_SAMPLES),
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_r     (cfg_r),
    .cfg_nxt   (cfg_nxt),
    .restart   (restart),
    .accept    (accept),
    .sample_in (in_tdata),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  brcd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_word   (res_word),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  // Pack result word
  assign out_tdata = {(OUT_TDATA_W - SAMPLE_W - DEST_W)'(0), out_word.sample, out_word.dest};
  assign out_tlast = out_word.capture_end;

endmodule

### rtl/core/brcd_cfg.sv
module brcd_cfg
  import brcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output brcd_cfg_t         cfg_r,
  output brcd_cfg_t         cfg_nxt,
  output logic              restart
);

  brcd_reg_t reg_sel;
  logic      wr_en;

  assign reg_sel = brcd_reg_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;

  // Register write decode; a write to a known register restarts the capture
  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (wr_en) begin
      case (reg_sel)
        REG_ROW_GROUPS: begin
          cfg_nxt.row_groups = pwdata[GROUPS_W-1:0];
          restart = 1'b1;
        end
        REG_SAMPLES: begin
          cfg_nxt.samples = pwdata[SPC_W-1:0];
          restart = 1'b1;
        end
        REG_BYPASS: begin
          cfg_nxt.bypass = pwdata[0];
          restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_groups <= RST_GROUPS;
      cfg_r.samples    <= RST_SAMPLES;
      cfg_r.bypass     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_ROW_GROUPS: prdata = CFG_DW'(cfg_r.row_groups);
      REG_SAMPLES:    prdata = CFG_DW'(cfg_r.samples);
      REG_BYPASS:     prdata = CFG_DW'(cfg_r.bypass);
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/core/brcd_addr.sv
module brcd_addr
  import brcd_pkg::*;
#(
  parameter int ROW_SAMPLES = 128,
  parameter int MAX_GROUPS  = 8,
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brcd_cfg_t                  cfg_r,
  input  brcd_cfg_t                  cfg_nxt,
  input  logic                       restart,
  input  logic                       accept,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       res_valid,
  output brcd_word_t                 res_word
);

  localparam int SW  = (ROW_SAMPLES > 1) ? $clog2(ROW_SAMPLES) : 1;
  localparam int GCW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // Clamp samples per channel to 1..MAX_SAMPLES
  function automatic logic [SPC_W-1:0] eff_spc(input logic [SPC_W-1:0] s);
    logic [SPC_W-1:0] r;
    if (s == '0) r = SPC_W'(1);
    else if (32'(s) > 32'(MAX_SAMPLES)) r = SPC_W'(MAX_SAMPLES);
    else r = s;
    return r;
  endfunction

  // Counters; chan_base is (group*8+lane)*spc, pos is block*ROW_SAMPLES+sample
  logic [LANE_W-1:0] lane_r,       lane_nxt;
  logic [SW-1:0]     sample_r,     sample_nxt;
  logic [GCW-1:0]    group_r,      group_nxt;
  logic [SPC_W-1:0]  rem_r,        rem_nxt;        // samples left from block start
  logic [DEST_W-1:0] chan_base_r,  chan_base_nxt;
  logic [DEST_W-1:0] group_base_r, group_base_nxt;
  logic [SPC_W-1:0]  pos_r,        pos_nxt;
  logic [SPC_W-1:0]  blk_base_r,   blk_base_nxt;

  logic [SPC_W-1:0]  spc;
  logic [4:0]        grp_lim;
  logic              last_lane, last_sam, last_grp, last_blk;
  logic [DEST_W-1:0] chan_inc;

  assign spc = eff_spc(cfg_r.samples);

  // Last group index after clamping row_groups to 1..MAX_GROUPS
  always_comb begin
    if (cfg_r.row_groups == '0) grp_lim = 5'd0;
    else if (5'(cfg_r.row_groups) > 5'(MAX_GROUPS)) grp_lim = 5'(MAX_GROUPS - 1);
    else grp_lim = 5'(cfg_r.row_groups) - 5'd1;
  end

  assign last_lane = (lane_r == LANE_W'(LANES - 1));
  assign last_blk  = (rem_r <= SPC_W'(ROW_SAMPLES));
  assign last_sam  = last_blk ? ((SPC_W'(sample_r) + SPC_W'(1)) == rem_r)
                              : (sample_r == SW'(ROW_SAMPLES - 1));
  assign last_grp  = (5'(group_r) == grp_lim);
  assign chan_inc  = chan_base_r + DEST_W'(spc);

  // Counter advance
  always_comb begin
    lane_nxt       = lane_r;
    sample_nxt     = sample_r;
    group_nxt      = group_r;
    rem_nxt        = rem_r;
    chan_base_nxt  = chan_base_r;
    group_base_nxt = group_base_r;
    pos_nxt        = pos_r;
    blk_base_nxt   = blk_base_r;
    if (!last_lane) begin
      lane_nxt      = lane_r + LANE_W'(1);
      chan_base_nxt = chan_inc;
    end else begin
      lane_nxt = '0;
      if (!last_sam) begin
        sample_nxt    = sample_r + SW'(1);
        pos_nxt       = pos_r + SPC_W'(1);
        chan_base_nxt = group_base_r;
      end else begin
        sample_nxt = '0;
        if (!last_grp) begin
          group_nxt      = group_r + GCW'(1);
          chan_base_nxt  = chan_inc;
          group_base_nxt = chan_inc;
          pos_nxt        = blk_base_r;
        end else begin
          group_nxt      = '0;
          chan_base_nxt  = '0;
          group_base_nxt = '0;
          if (!last_blk) begin
            blk_base_nxt = blk_base_r + SPC_W'(ROW_SAMPLES);
            pos_nxt      = blk_base_r + SPC_W'(ROW_SAMPLES);
            rem_nxt      = rem_r - SPC_W'(ROW_SAMPLES);
          end else begin
            blk_base_nxt = '0;
            pos_nxt      = '0;
            rem_nxt      = spc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      lane_r       <= '0;
      sample_r     <= '0;
      group_r      <= '0;
      chan_base_r  <= '0;
      group_base_r <= '0;
      pos_r        <= '0;
      blk_base_r   <= '0;
      rem_r        <= !rst_n ? eff_spc(RST_SAMPLES) : eff_spc(cfg_nxt.samples);
    end else if (accept) begin
      lane_r       <= lane_nxt;
      sample_r     <= sample_nxt;
      group_r      <= group_nxt;
      chan_base_r  <= chan_base_nxt;
      group_base_r <= group_base_nxt;
      pos_r        <= pos_nxt;
      blk_base_r   <= blk_base_nxt;
      rem_r        <= rem_nxt;
    end
  end

  // Result word for the current position
  assign res_valid            = accept & ~cfg_r.bypass;
  assign res_word.dest        = chan_base_r + DEST_W'(pos_r);
  assign res_word.sample      = sample_in;
  assign res_word.capture_end = last_lane & last_sam & last_grp & last_blk;

endmodule

### rtl/core/brcd_skid.sv
module brcd_skid
  import brcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  brcd_word_t in_word,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output brcd_word_t out_word
);

  logic       main_valid_r;
  brcd_word_t main_word_r;
  logic       skid_valid_r;
  brcd_word_t skid_word_r;

  // Ready depends only on the skid slot, so it is a register output
  assign in_ready  = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_word  = main_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (out_ready || !main_valid_r) begin
      main_word_r <= skid_valid_r ? skid_word_r : in_word;
    end else if (in_valid) begin
      skid_word_r <= in_word;
    end
  end

endmodule

### rtl/core/brcd_check.sv
module brcd_check
  import brcd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   cfg_pready
);

  // Reset leaves the output empty and the input open
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty or input blocked after reset");

  // A stalled word holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Input closes only after an output stall
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("in_tready low without an output stall");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

endmodule

bind block_row_channel_deinterleave brcd_check u_brcd_check (.*);
